// ===== rtl/rij256_pkg.sv =====
package rij256_pkg;

    typedef struct packed {
        logic        operation;
        logic [63:0] block_in_0;
        logic [63:0] block_in_1;
        logic [63:0] block_in_2;
        logic [63:0] block_in_3;
        logic        last_block;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] block_out_0;
        logic [63:0] block_out_1;
        logic [63:0] block_out_2;
        logic [63:0] block_out_3;
        logic        last_out;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND,
        ST_DONE
    } state_t;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam int NUM_ROUNDS  = 14;
    localparam int KEY_ENTRIES = 60;
    localparam int KEY_REGS    = 4;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0:    r = 8'h01;
            4'd1:    r = 8'h02;
            4'd2:    r = 8'h04;
            4'd3:    r = 8'h08;
            4'd4:    r = 8'h10;
            4'd5:    r = 8'h20;
            4'd6:    r = 8'h40;
            4'd7:    r = 8'h80;
            4'd8:    r = 8'h1B;
            4'd9:    r = 8'h36;
            4'd10:   r = 8'h6C;
            4'd11:   r = 8'hD8;
            4'd12:   r = 8'hAB;
            4'd13:   r = 8'h4D;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
        logic [7:0] a [4];
        logic [7:0] a2 [4];
        logic [7:0] a4 [4];
        logic [7:0] a8 [4];
        logic [7:0] m0, m1, m2, m3;
        logic [31:0] o;
        for (int r = 0; r < 4; r++) begin
            a[r]  = c[8*r +: 8];
            a2[r] = xt(a[r]);
            a4[r] = xt(a2[r]);
            a8[r] = xt(a4[r]);
        end
        for (int r = 0; r < 4; r++) begin
            if (inv) begin
                m0 = a8[r] ^ a4[r] ^ a2[r];
                m1 = a8[(r+1)%4] ^ a2[(r+1)%4] ^ a[(r+1)%4];
                m2 = a8[(r+2)%4] ^ a4[(r+2)%4] ^ a[(r+2)%4];
                m3 = a8[(r+3)%4] ^ a[(r+3)%4];
            end
            else begin
                m0 = a2[r];
                m1 = a2[(r+1)%4] ^ a[(r+1)%4];
                m2 = a[(r+2)%4];
                m3 = a[(r+3)%4];
            end
            o[8*r +: 8] = m0 ^ m1 ^ m2 ^ m3;
        end
        return o;
    endfunction

endpackage

// ===== rtl/rijndael_256_block_cipher.sv =====
// Rijndael-256/256 ECB engine. One beat in, one beat out. After a beat is accepted, the
// LOAD state does the first key add and the ROUND state runs the 14 rounds, one round per
// cycle, through a shared round unit; the result is then offered in DONE. The next beat
// is accepted only after the result leaves and the engine is back in IDLE. After reset
// or any key write, a waiting beat is held off (a start step, then 112 schedule words)
// while the key schedule runs one 32-bit word per cycle through a shared S-box word
// unit.
module rijndael_256_block_cipher (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [63:0]             cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  rij256_pkg::in_beat_t    in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output rij256_pkg::out_beat_t   out_data
);

    rij256_pkg::state_t state_reg, state_next;
    logic [255:0] key_reg;
    logic         stale_reg;
    logic [255:0] win_reg;
    logic [6:0]   wi_reg;
    logic [3:0]   rnd_reg;
    logic [255:0] st_reg;
    logic         op_reg;
    logic         last_reg;
    logic [255:0] rk_mem [15];
    logic [255:0] rk_rd_reg;
    logic [3:0]   rk_addr;
    logic [255:0] lastpack;
    logic         exp_start;

    logic [31:0] wprev, wt, wnew;
    logic [255:0] sr, sb, mx, rnd_out, ld_state;

    assign cfg_ready = (state_reg == rij256_pkg::ST_IDLE);
    assign in_ready  = (state_reg == rij256_pkg::ST_IDLE) && !cfg_valid && !stale_reg;
    assign out_valid = (state_reg == rij256_pkg::ST_DONE);
    assign out_data  = {st_reg[63:0], st_reg[127:64], st_reg[191:128], st_reg[255:192], last_reg};
    assign exp_start = (state_reg == rij256_pkg::ST_IDLE) && in_valid && !cfg_valid && stale_reg;

    // key schedule: window holds the last 8 words
    assign wprev = win_reg[255:224];
    always_comb
    begin
        wt = wprev;
        if (wi_reg[2:0] == 3'd0)
        begin
            for (int b = 0; b < 4; b++)
                wt[8*b +: 8] = rij256_pkg::sbox(wprev[8*((b+1)%4) +: 8]);
            wt[7:0] = wt[7:0] ^ rij256_pkg::rcon(4'(wi_reg[6:3] - 4'd1));
        end
        else if (wi_reg[2:0] == 3'd4)
        begin
            for (int b = 0; b < 4; b++)
                wt[8*b +: 8] = rij256_pkg::sbox(wprev[8*b +: 8]);
        end
        wnew = win_reg[31:0] ^ wt;
    end
    assign lastpack = {wnew, win_reg[255:32]};

    // round datapath
    always_comb
    begin
        for (int c = 0; c < 8; c++)
            for (int r = 0; r < 4; r++)
            begin
                if (op_reg == rij256_pkg::OP_DECRYPT)
                    sr[8*(4*((c + (r == 3 ? 4 : r == 2 ? 3 : r)) % 8) + r) +: 8]
                        = rij256_pkg::inv_sbox(st_reg[8*(4*c + r) +: 8]);
                else
                    sr[8*(4*c + r) +: 8]
                        = rij256_pkg::sbox(st_reg[8*(4*((c + (r == 3 ? 4 : r == 2 ? 3 : r)) % 8)
                                                      + r) +: 8]);
            end
        sb = sr;
        if (op_reg == rij256_pkg::OP_DECRYPT)
        begin
            sb = sr ^ rk_rd_reg;
            for (int c = 0; c < 8; c++)
                mx[32*c +: 32] = rij256_pkg::mix_col(sb[32*c +: 32], 1'b1);
            rnd_out = (rnd_reg == 4'd14) ? sb : mx;
        end
        else
        begin
            for (int c = 0; c < 8; c++)
                mx[32*c +: 32] = rij256_pkg::mix_col(sb[32*c +: 32], 1'b0);
            rnd_out = ((rnd_reg == 4'd14) ? sb : mx) ^ rk_rd_reg;
        end
    end

    // rk_rd_reg read for the next cycle
    always_comb
    begin
        rk_addr = 4'd0;
        if (state_reg == rij256_pkg::ST_IDLE)
            rk_addr = (in_data.operation == rij256_pkg::OP_DECRYPT) ? 4'd14 : 4'd0;
        else if (state_reg == rij256_pkg::ST_LOAD)
            rk_addr = (op_reg == rij256_pkg::OP_DECRYPT) ? 4'd13 : 4'd1;
        else if (state_reg == rij256_pkg::ST_ROUND && rnd_reg != 4'd14)
            rk_addr = (op_reg == rij256_pkg::OP_DECRYPT) ? 4'(4'd13 - rnd_reg) : 4'(rnd_reg + 4'd1);
    end

    always_ff @(posedge clk)
    begin
        rk_rd_reg <= rk_mem[rk_addr];
        if (exp_start)
            rk_mem[0] <= key_reg;
        else if (state_reg == rij256_pkg::ST_EXPAND && wi_reg[2:0] == 3'd7)
            rk_mem[wi_reg[6:3]] <= lastpack;
    end

    assign ld_state = {in_data.block_in_3, in_data.block_in_2, in_data.block_in_1,
                       in_data.block_in_0};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rij256_pkg::ST_IDLE:
                if (in_valid && !cfg_valid)
                    state_next = stale_reg ? rij256_pkg::ST_EXPAND : rij256_pkg::ST_LOAD;
            rij256_pkg::ST_EXPAND:
                if (wi_reg == 7'd119)
                    state_next = rij256_pkg::ST_IDLE;
            rij256_pkg::ST_LOAD:
                state_next = rij256_pkg::ST_ROUND;
            rij256_pkg::ST_ROUND:
                if (rnd_reg == 4'd14)
                    state_next = rij256_pkg::ST_DONE;
            rij256_pkg::ST_DONE:
                if (out_ready)
                    state_next = rij256_pkg::ST_IDLE;
            default:
                state_next = rij256_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rij256_pkg::ST_IDLE;
            key_reg   <= '0;
            stale_reg <= 1'b1;
            wi_reg    <= '0;
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                key_reg[64*cfg_index +: 64] <= cfg_data;
                stale_reg <= 1'b1;
            end
            if (exp_start)
                wi_reg <= 7'd8;
            else if (state_reg == rij256_pkg::ST_EXPAND)
            begin
                wi_reg <= wi_reg + 7'd1;
                if (wi_reg == 7'd119)
                    stale_reg <= 1'b0;
            end
            if (state_reg == rij256_pkg::ST_LOAD)
                rnd_reg <= 4'd1;
            else if (state_reg == rij256_pkg::ST_ROUND)
                rnd_reg <= rnd_reg + 4'd1;
        end
    end

    // stale path: item is not consumed; expansion runs then beat is re-offered
    always_ff @(posedge clk)
    begin
        if (state_reg == rij256_pkg::ST_IDLE && in_valid && !cfg_valid)
        begin
            if (stale_reg)
                win_reg <= key_reg;
            else
            begin
                op_reg   <= in_data.operation;
                last_reg <= in_data.last_block;
                st_reg   <= ld_state;
            end
        end
        else if (state_reg == rij256_pkg::ST_EXPAND)
            win_reg <= lastpack;
        else if (state_reg == rij256_pkg::ST_LOAD)
            st_reg <= st_reg ^ rk_rd_reg;
        else if (state_reg == rij256_pkg::ST_ROUND)
            st_reg <= rnd_out;
    end

endmodule
